[design/dvrt_pkg.sv]
// ----------------------------------------------------------------------------
// dvrt_pkg
// shared types and constants for the distance-vector route table
// ----------------------------------------------------------------------------
package dvrt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int NUM_IFACES    = 8;
	localparam int ADDR_BITS     = 16;
	localparam int METRIC_BITS   = 8;
	localparam int IFACE_BITS    = 3;
	localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);

	localparam logic [METRIC_BITS-1:0] METRIC_MAX = {METRIC_BITS{1'b1}};
	localparam logic [METRIC_BITS-1:0] METRIC_ONE = METRIC_BITS'(1);

	localparam logic [1:0] CMD_INIT   = 2'd0;
	localparam logic [1:0] CMD_MERGE  = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	// operation broadcast along the chain
	typedef enum logic [1:0] {
		OP_NONE,
		OP_SEARCH,
		OP_UPDATE,
		OP_INSERT
	} op_t;

	typedef struct packed {
		op_t                    op;
		logic [ADDR_BITS-1:0]   dest;
		logic [ADDR_BITS-1:0]   nbr;
		logic [IFACE_BITS-1:0]  ifc;
		logic [METRIC_BITS-1:0] metric;
	} bus_t;

	// results flowing through the chain
	typedef struct packed {
		logic                   dest_hit;
		logic [METRIC_BITS-1:0] dest_best;
		logic [IFACE_BITS-1:0]  dest_hop;
		logic [METRIC_BITS-1:0] dest_ifm;
		logic                   nbr_hit;
		logic [METRIC_BITS-1:0] nbr_best;
		logic                   free_seen;
	} res_t;

endpackage

[design/dvrt_cell.sv]
// ----------------------------------------------------------------------------
// dvrt_cell
// one table entry: address match, per-interface metrics, in-place update
// ----------------------------------------------------------------------------
module dvrt_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  dvrt_pkg::bus_t bus,
	input  dvrt_pkg::res_t res_in,
	output dvrt_pkg::res_t res_out
);
	import dvrt_pkg::*;

	logic                   valid_q;
	logic [ADDR_BITS-1:0]   addr_q;
	logic [METRIC_BITS-1:0] best_q;
	logic [IFACE_BITS-1:0]  hop_q;
	logic [METRIC_BITS-1:0] ifm_q [NUM_IFACES];

	logic dhit, nhit, claim;

	assign dhit  = valid_q && addr_q == bus.dest;
	assign nhit  = valid_q && addr_q == bus.nbr;
	// first free cell claims an insert
	assign claim = !valid_q && !res_in.free_seen;

	always_comb begin
		res_out = res_in;
		if (dhit) begin
			res_out.dest_hit  = 1'b1;
			res_out.dest_best = best_q;
			res_out.dest_hop  = hop_q;
			res_out.dest_ifm  = ifm_q[bus.ifc];
		end
		if (nhit) begin
			res_out.nbr_hit  = 1'b1;
			res_out.nbr_best = best_q;
		end
		if (!valid_q)
			res_out.free_seen = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (bus.op == OP_INSERT && claim) begin
			valid_q <= 1'b1;
		end
	end

	// payload: match lowers, insert writes the whole entry
	always_ff @(posedge clk) begin
		if (bus.op == OP_UPDATE && dhit) begin
			if (ifm_q[bus.ifc] > bus.metric) begin
				ifm_q[bus.ifc] <= bus.metric;
				if (best_q > bus.metric) begin
					best_q <= bus.metric;
					hop_q  <= bus.ifc;
				end
			end
		end else if (bus.op == OP_INSERT && claim) begin
			addr_q <= bus.dest;
			best_q <= bus.metric;
			hop_q  <= bus.ifc;
			for (int k = 0; k < NUM_IFACES; k++)
				ifm_q[k] <= (IFACE_BITS'(k) == bus.ifc) ? bus.metric : METRIC_MAX;
		end
	end

endmodule

[design/distance_vector_route_table.sv]
// ----------------------------------------------------------------------------
// distance_vector_route_table
// distance-vector routing table built as a row of entry cells
// ----------------------------------------------------------------------------
// a start is accepted only while idle; each transaction then steps through the
// search (with the metric combine), update and done states before the next start
// is taken, search and update sharing the one cell row. reset clears all entry valid bits and the
// advertisement change flag at once; the receiver cannot stall results.
module distance_vector_route_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    cmd,
	input  logic [dvrt_pkg::ADDR_BITS-1:0] dest_address,
	input  logic [dvrt_pkg::ADDR_BITS-1:0] neighbor_address,
	input  logic [dvrt_pkg::IFACE_BITS-1:0] iface,
	input  logic [dvrt_pkg::METRIC_BITS-1:0] adv_metric,
	input  logic                          last,
	output logic                          done,
	output logic                          hit,
	output logic [dvrt_pkg::IFACE_BITS-1:0] next_iface,
	output logic                          changed,
	output logic                          run_changed,
	output logic                          table_full
);
	import dvrt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE,
		ST_DONE
	} state_t;

	state_t state_q;

	// captured transaction
	logic [1:0]             cmd_q;
	logic [ADDR_BITS-1:0]   dest_q;
	logic [ADDR_BITS-1:0]   nbr_q;
	logic [IFACE_BITS-1:0]  ifc_q;
	logic [METRIC_BITS-1:0] adv_q;
	logic                   last_q;
	logic [METRIC_BITS-1:0] metric_q;
	logic                   advert_changed_q;

	// registered search results
	res_t srch_q;

	bus_t bus;
	res_t chain [TABLE_ENTRIES+1];

	assign chain[0] = '0;

	// broadcast: search reads the row; update, for init and merge commands, lets the
	// matching cell lower its metrics, or the first free cell insert when no cell matched
	always_comb begin
		bus.op = OP_NONE;
		if (state_q == ST_SEARCH)
			bus.op = OP_SEARCH;
		else if (state_q == ST_UPDATE && (cmd_q == CMD_INIT || cmd_q == CMD_MERGE))
			bus.op = srch_q.dest_hit ? OP_UPDATE : OP_INSERT;
		bus.dest   = dest_q;
		bus.nbr    = nbr_q;
		bus.ifc    = ifc_q;
		bus.metric = metric_q;
	end

	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		dvrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.bus    (bus),
			.res_in (chain[g]),
			.res_out(chain[g+1])
		);
	end

	// saturating neighbor plus advertised metric
	logic [METRIC_BITS-1:0] nbr_m;
	logic [METRIC_BITS:0]   sum;
	logic [METRIC_BITS-1:0] comb_metric;

	always_comb begin
		nbr_m = chain[TABLE_ENTRIES].nbr_hit ? chain[TABLE_ENTRIES].nbr_best : METRIC_MAX;
		sum   = {1'b0, nbr_m} + {1'b0, adv_q};
		if (nbr_m == METRIC_MAX || adv_q == METRIC_MAX || sum[METRIC_BITS])
			comb_metric = METRIC_MAX;
		else
			comb_metric = sum[METRIC_BITS-1:0];
	end

	logic upd_cmd, did_change, did_full;

	assign upd_cmd    = cmd_q == CMD_INIT || cmd_q == CMD_MERGE;
	assign did_change = upd_cmd && (srch_q.dest_hit ? (srch_q.dest_ifm > metric_q)
	                                                : srch_q.free_seen);
	assign did_full   = upd_cmd && !srch_q.dest_hit && !srch_q.free_seen;

	assign busy = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			advert_changed_q <= 1'b0;
			done             <= 1'b0;
			hit              <= 1'b0;
			next_iface       <= '0;
			changed          <= 1'b0;
			run_changed      <= 1'b0;
			table_full       <= 1'b0;
			cmd_q            <= CMD_INIT;
			last_q           <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						last_q  <= last;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					// cells write this cycle; flags come from the registered search
					done        <= 1'b1;
					hit         <= cmd_q == CMD_LOOKUP && srch_q.dest_hit;
					next_iface  <= (cmd_q == CMD_LOOKUP && srch_q.dest_hit)
					               ? srch_q.dest_hop : '0;
					changed     <= did_change;
					table_full  <= did_full;
					run_changed <= cmd_q == CMD_MERGE && last_q
					               && (advert_changed_q || did_change);
					if (cmd_q == CMD_MERGE) begin
						if (last_q)
							advert_changed_q <= 1'b0;
						else if (did_change)
							advert_changed_q <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			dest_q <= dest_address;
			nbr_q  <= neighbor_address;
			ifc_q  <= iface;
			adv_q  <= adv_metric;
		end
		if (state_q == ST_SEARCH) begin
			srch_q   <= chain[TABLE_ENTRIES];
			metric_q <= (cmd_q == CMD_INIT) ? METRIC_ONE : comb_metric;
		end
	end

endmodule
